// ----- rtl/psf_pkg.sv -----
// shared widths and item types for the spring force block
`timescale 1ns / 1ps
package psf_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int CFG_W       = 31;
	localparam int CFG_IDX_W   = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPRING_CONSTANT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH     = 1'd1;

	localparam int AD_W     = COORD_WIDTH + 1;
	localparam int SUM_W    = 2 * AD_W;
	localparam int LEN_W    = AD_W;
	localparam int PROD_W   = CFG_W + LEN_W;
	localparam int MAG_W    = PROD_W - FRAC_BITS;
	localparam int MAG_LO_W = MAG_W / 2;
	localparam int MAG_HI_W = MAG_W - MAG_LO_W;
	localparam int NUM_W    = MAG_W + AD_W;
	localparam int Q_W      = MAG_W;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = QPTR_W + 1;

	typedef logic [CFG_W-1:0] cfg_t;
	typedef logic [AD_W-1:0]  ad_t;
	typedef logic [LEN_W-1:0] len_t;

	// separation magnitudes and sign per axis
	typedef struct packed {
		ad_t [2:0]  ad;
		logic [2:0] pos;
	} geo_t;

	// one classified item between front and back
	typedef struct packed {
		len_t len;
		geo_t geo;
	} item_t;

endpackage

// ----- rtl/psf_front.sv -----
// front end: separation, squared length and pipelined square root
`timescale 1ns / 1ps
module psf_front import psf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] own_x,
	input  logic signed [COORD_WIDTH-1:0] own_y,
	input  logic signed [COORD_WIDTH-1:0] own_z,
	input  logic signed [COORD_WIDTH-1:0] anchor_x,
	input  logic signed [COORD_WIDTH-1:0] anchor_y,
	input  logic signed [COORD_WIDTH-1:0] anchor_z,
	output logic                          out_valid,
	output item_t                         out_item
);

	localparam int TW = SUM_W + 2;

	logic signed [AD_W-1:0] d [3];
	geo_t geo_c;

	logic             v_s1, v_s2, v_s3;
	geo_t             geo_s1, geo_s2, geo_s3;
	logic [SUM_W-1:0] sq_s2 [3];
	logic [SUM_W-1:0] sum_s3;

	logic             v_a   [LEN_W+1];
	geo_t             geo_a [LEN_W+1];
	logic [SUM_W-1:0] rem_a [LEN_W+1];
	len_t             root_a[LEN_W+1];

	always_comb begin
		d[0] = {own_x[COORD_WIDTH-1], own_x} - {anchor_x[COORD_WIDTH-1], anchor_x};
		d[1] = {own_y[COORD_WIDTH-1], own_y} - {anchor_y[COORD_WIDTH-1], anchor_y};
		d[2] = {own_z[COORD_WIDTH-1], own_z} - {anchor_z[COORD_WIDTH-1], anchor_z};
		for (int i = 0; i < 3; i++) begin
			geo_c.ad[i]  = d[i][AD_W-1] ? ad_t'(-d[i]) : ad_t'(d[i]);
			geo_c.pos[i] = !d[i][AD_W-1] && (d[i] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		geo_s1 <= geo_c;
		geo_s2 <= geo_s1;
		geo_s3 <= geo_s2;
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= geo_s1.ad[i] * geo_s1.ad[i];
		end
		sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	assign v_a[0]    = v_s3;
	assign geo_a[0]  = geo_s3;
	assign rem_a[0]  = sum_s3;
	assign root_a[0] = '0;

	// one root bit per stage, msb first, remainder kept as n - root^2
	for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
		localparam int B = LEN_W - 1 - k;
		logic [TW-1:0]    t;
		logic             take;
		logic             v_q;
		geo_t             geo_q;
		logic [SUM_W-1:0] rem_q;
		len_t             root_q;

		assign t    = (TW'(root_a[k]) << (B + 1)) | (TW'(1) << (2 * B));
		assign take = t <= TW'(rem_a[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else begin
				v_q <= v_a[k];
			end
		end

		always_ff @(posedge clk) begin
			geo_q  <= geo_a[k];
			rem_q  <= take ? rem_a[k] - t[SUM_W-1:0] : rem_a[k];
			root_q <= take ? root_a[k] | (len_t'(1) << B) : root_a[k];
		end

		assign v_a[k+1]    = v_q;
		assign geo_a[k+1]  = geo_q;
		assign rem_a[k+1]  = rem_q;
		assign root_a[k+1] = root_q;
	end

	assign out_valid    = v_a[LEN_W];
	assign out_item.len = root_a[LEN_W];
	assign out_item.geo = geo_a[LEN_W];

endmodule

// ----- rtl/psf_queue.sv -----
// short queue between front and back
`timescale 1ns / 1ps
module psf_queue import psf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  pop,
	output item_t pop_item,
	output logic  nearly_full
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	// back end never stalls, so anything waiting moves on every cycle
	assign pop         = cnt_q != '0;
	assign pop_item    = mem_q[rd_q];
	assign nearly_full = cnt_q >= QCNT_W'(QDEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == QCNT_W'(QDEPTH)))
		else $error("queue overflow");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not follow a push");
`endif

endmodule

// ----- rtl/psf_back.sv -----
// back end: magnitude, per-axis scaling, pipelined divide and saturation
`timescale 1ns / 1ps
module psf_back import psf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  item_t                         in_item,
	input  cfg_t                          spring_constant,
	input  cfg_t                          rest_length,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] force_x,
	output logic signed [COORD_WIDTH-1:0] force_y,
	output logic signed [COORD_WIDTH-1:0] force_z,
	output logic                          saturated
);

	localparam logic [Q_W-1:0] POS_MAX = Q_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
	localparam logic [Q_W-1:0] NEG_MAG = Q_W'(64'd1 << (COORD_WIDTH - 1));

	typedef struct packed {
		len_t       len;
		logic [2:0] pos;
		logic       zero;
	} ctl_t;

	len_t rest_ext;
	logic [MAG_W-1:0] mag;

	logic v_s1, v_s2, v_s3, v_s4;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	ad_t [2:0] ad_s1, ad_s2;
	len_t diff_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [MAG_HI_W+AD_W-1:0] pph_s3 [3];
	logic [MAG_LO_W+AD_W-1:0] ppl_s3 [3];
	logic [NUM_W-1:0] num_s4 [3];

	logic             v_a   [Q_W+1];
	ctl_t             ctl_a [Q_W+1];
	logic [NUM_W-1:0] rem_a [Q_W+1][3];
	logic [Q_W-1:0]   quo_a [Q_W+1][3];

	logic signed [COORD_WIDTH-1:0] frc_c [3];
	logic [2:0] sat_c;
	logic v_q;
	logic signed [COORD_WIDTH-1:0] fx_q, fy_q, fz_q;
	logic sat_q;

	assign rest_ext = len_t'(rest_length);
	assign mag      = prod_s2[PROD_W-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1.len  <= in_item.len;
		ctl_s1.pos  <= in_item.geo.pos;
		ctl_s1.zero <= in_item.len == '0;
		ad_s1       <= in_item.geo.ad;
		diff_s1     <= (in_item.len >= rest_ext) ? in_item.len - rest_ext
		                                         : rest_ext - in_item.len;
		ctl_s2  <= ctl_s1;
		ad_s2   <= ad_s1;
		prod_s2 <= spring_constant * diff_s1;
		ctl_s3  <= ctl_s2;
		ctl_s4  <= ctl_s3;
		for (int i = 0; i < 3; i++) begin
			pph_s3[i] <= mag[MAG_W-1:MAG_LO_W] * ad_s2[i];
			ppl_s3[i] <= mag[MAG_LO_W-1:0] * ad_s2[i];
			num_s4[i] <= (NUM_W'(pph_s3[i]) << MAG_LO_W) + NUM_W'(ppl_s3[i]);
		end
	end

	assign v_a[0]   = v_s4;
	assign ctl_a[0] = ctl_s4;
	for (genvar i = 0; i < 3; i++) begin : g_init
		assign rem_a[0][i] = num_s4[i];
		assign quo_a[0][i] = '0;
	end

	// restoring divide by the length, one quotient bit per stage on all axes
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		localparam int B = Q_W - 1 - k;
		logic [NUM_W-1:0] trial;
		logic             v_q2;
		ctl_t             ctl_q;
		logic [NUM_W-1:0] rem_q [3];
		logic [Q_W-1:0]   quo_q [3];

		assign trial = NUM_W'(ctl_a[k].len) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q2 <= 1'b0;
			end else begin
				v_q2 <= v_a[k];
			end
		end

		always_ff @(posedge clk) begin
			ctl_q <= ctl_a[k];
			for (int i = 0; i < 3; i++) begin
				if (rem_a[k][i] >= trial) begin
					rem_q[i] <= rem_a[k][i] - trial;
					quo_q[i] <= quo_a[k][i] | (Q_W'(1) << B);
				end else begin
					rem_q[i] <= rem_a[k][i];
					quo_q[i] <= quo_a[k][i];
				end
			end
		end

		assign v_a[k+1]   = v_q2;
		assign ctl_a[k+1] = ctl_q;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			assign rem_a[k+1][i] = rem_q[i];
			assign quo_a[k+1][i] = quo_q[i];
		end
	end

	// sign from the separation, clamp to the output range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ctl_a[Q_W].zero) begin
				frc_c[i] = '0;
				sat_c[i] = 1'b0;
			end else if (ctl_a[Q_W].pos[i]) begin
				sat_c[i] = quo_a[Q_W][i] > NEG_MAG;
				frc_c[i] = sat_c[i] ? COORD_WIDTH'(NEG_MAG)
				                    : -COORD_WIDTH'(quo_a[Q_W][i]);
			end else begin
				sat_c[i] = quo_a[Q_W][i] > POS_MAX;
				frc_c[i] = sat_c[i] ? COORD_WIDTH'(POS_MAX)
				                    : COORD_WIDTH'(quo_a[Q_W][i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_a[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		fx_q  <= frc_c[0];
		fy_q  <= frc_c[1];
		fz_q  <= frc_c[2];
		sat_q <= |sat_c;
	end

	assign out_valid = v_q;
	assign force_x   = fx_q;
	assign force_y   = fy_q;
	assign force_z   = fz_q;
	assign saturated = sat_q;

endmodule

// ----- rtl/particle_spring_force.sv -----
// top level: config registers, front end, queue and back end
//
// channel   signals                          transfer
// input     start, busy, own_*, anchor_*     start high and busy low at clk
// result    done, force_*, saturated         done high for one cycle
// config    wr_en, wr_index, wr_data         wr_en high at clk
//
// one item per cycle while busy is low; the path is front registers, square
// root, the queue, scaling registers, 48 divide stages and an output register.
// the square-root and divide pipelines, one bit per stage, set the latency.
// reset clears all valid bits and loads both registers with 1.0.
// done cannot be held off; busy only rises if the queue nearly fills.
`timescale 1ns / 1ps
module particle_spring_force import psf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] own_x,
	input  logic signed [COORD_WIDTH-1:0] own_y,
	input  logic signed [COORD_WIDTH-1:0] own_z,
	input  logic signed [COORD_WIDTH-1:0] anchor_x,
	input  logic signed [COORD_WIDTH-1:0] anchor_y,
	input  logic signed [COORD_WIDTH-1:0] anchor_z,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] force_x,
	output logic signed [COORD_WIDTH-1:0] force_y,
	output logic signed [COORD_WIDTH-1:0] force_z,
	output logic                          saturated,
	input  logic                          wr_en,
	input  logic [CFG_IDX_W-1:0]          wr_index,
	input  logic [CFG_W-1:0]              wr_data
);

	localparam cfg_t ONE_Q = cfg_t'(1) << FRAC_BITS;

	cfg_t  k_q, rest_q;
	logic  fr_valid, q_pop, q_nearly_full;
	item_t fr_item, q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= ONE_Q;
			rest_q <= ONE_Q;
		end else if (wr_en) begin
			case (wr_index)
				REG_SPRING_CONSTANT: k_q    <= wr_data;
				REG_REST_LENGTH:     rest_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = q_nearly_full;

	psf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.own_x    (own_x),
		.own_y    (own_y),
		.own_z    (own_z),
		.anchor_x (anchor_x),
		.anchor_y (anchor_y),
		.anchor_z (anchor_z),
		.out_valid(fr_valid),
		.out_item (fr_item)
	);

	psf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fr_valid),
		.push_item  (fr_item),
		.pop        (q_pop),
		.pop_item   (q_item),
		.nearly_full(q_nearly_full)
	);

	psf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (q_pop),
		.in_item        (q_item),
		.spring_constant(k_q),
		.rest_length    (rest_q),
		.out_valid      (done),
		.force_x        (force_x),
		.force_y        (force_y),
		.force_z        (force_z),
		.saturated      (saturated)
	);

`ifndef SYNTH
	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(force_x == {1'b1, {(COORD_WIDTH-1){1'b0}}} ||
			 force_x == {1'b0, {(COORD_WIDTH-1){1'b1}}} ||
			 force_y == {1'b1, {(COORD_WIDTH-1){1'b0}}} ||
			 force_y == {1'b0, {(COORD_WIDTH-1){1'b1}}} ||
			 force_z == {1'b1, {(COORD_WIDTH-1){1'b0}}} ||
			 force_z == {1'b0, {(COORD_WIDTH-1){1'b1}}}))
		else $error("saturated flag without a clamped component");
`endif

endmodule
